FILE: src/assert_macros.svh
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising edge, switched off while reset is low.
`define TRF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define TRF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/trfdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package trfdg_pkg;

	localparam int SLOTS  = 256;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int PEND_W = $clog2(SLOTS + 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] CMD_PUT     = 3'd0;
	localparam logic [2:0] CMD_GET     = 3'd1;
	localparam logic [2:0] CMD_PEND    = 3'd2;
	localparam logic [2:0] CMD_GAP     = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_WRITE = 3'd1,
		OP_READ  = 3'd2,
		OP_PEND  = 3'd3,
		OP_GAP   = 3'd4
	} op_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [7:0]  kind;
		logic [31:0] wa;
		logic [31:0] wb;
	} rec_t;

	// pending count rides in rec.stamp; gap: wa count, wb first stamp, stamp span
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		rec_t             rec;
	} job_t;

endpackage
`default_nettype wire

FILE: src/trfdg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module trfdg_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [2:0]         command,
	input  wire logic [7:0]         kind,
	input  wire logic [31:0]        word_a,
	input  wire logic [31:0]        word_b,
	input  wire logic [31:0]        cycle_stamp,
	input  wire logic [31:0]        start_index,
	output trfdg_pkg::job_t         job
);
	import trfdg_pkg::*;

	logic [31:0]      head_q, tail_q;
	logic [IDX_W-1:0] head_idx_q, tail_idx_q;
	logic [31:0]      drop_q, first_q, last_q;
	logic [31:0]      fill;
	logic             room, avail;

	assign fill  = head_q - tail_q;
	assign room  = (fill < 32'(SLOTS));
	assign avail = (fill != 32'd0);

	always_comb begin
		job = '0;
		job.op = OP_NONE;
		case (command)
			CMD_PUT: begin
				if (room) begin
					job.op = OP_WRITE;
					job.idx = head_idx_q;
					job.rec.stamp = cycle_stamp;
					job.rec.kind = kind;
					job.rec.wa = word_a;
					job.rec.wb = word_b;
				end
			end
			CMD_GET: begin
				if (avail) begin
					job.op = OP_READ;
					job.idx = tail_idx_q;
				end
			end
			CMD_PEND: begin
				job.op = OP_PEND;
				job.rec.stamp = (fill > 32'(SLOTS)) ? 32'(SLOTS) : fill;
			end
			CMD_GAP: begin
				if (drop_q != 32'd0) begin
					job.op = OP_GAP;
					job.rec.wa = drop_q;
					job.rec.wb = first_q;
					job.rec.stamp = last_q - first_q;
				end
			end
			default: begin
				job.op = OP_NONE;
			end
		endcase
	end

	// slot pointers restart at zero: only slots written since restart are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			head_idx_q <= '0;
			tail_idx_q <= '0;
			drop_q <= '0;
			first_q <= '0;
			last_q <= '0;
		end else if (accept) begin
			case (command)
				CMD_PUT: begin
					if (room) begin
						head_q <= head_q + 32'd1;
						head_idx_q <= (head_idx_q == IDX_W'(SLOTS - 1)) ? '0
							: head_idx_q + IDX_W'(1);
					end else begin
						if (drop_q == 32'd0)
							first_q <= cycle_stamp;
						drop_q <= drop_q + 32'd1;
						last_q <= cycle_stamp;
					end
				end
				CMD_GET: begin
					if (avail) begin
						tail_q <= tail_q + 32'd1;
						tail_idx_q <= (tail_idx_q == IDX_W'(SLOTS - 1)) ? '0
							: tail_idx_q + IDX_W'(1);
					end
				end
				CMD_GAP: begin
					drop_q <= '0;
				end
				CMD_RESTART: begin
					head_q <= start_index;
					tail_q <= start_index;
					head_idx_q <= '0;
					tail_idx_q <= '0;
					drop_q <= '0;
					first_q <= '0;
					last_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/trfdg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module trfdg_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire trfdg_pkg::job_t din,
	input  wire logic        pop,
	output logic             full,
	output logic             empty,
	output trfdg_pkg::job_t  dout
);
	import trfdg_pkg::*;

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/trfdg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module trfdg_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid,
	input  wire trfdg_pkg::job_t               job,
	output logic                               strobe,
	output logic                               done_res,
	output logic [31:0]                        rec_stamp,
	output logic [7:0]                         rec_kind,
	output logic [31:0]                        rec_a,
	output logic [31:0]                        rec_b,
	output logic [trfdg_pkg::PEND_W-1:0]       pending_count,
	output logic [31:0]                        dropped_count,
	output logic [31:0]                        first_drop_stamp,
	output logic [31:0]                        drop_span
);
	import trfdg_pkg::*;

	rec_t mem_q [SLOTS];
	rec_t rd_s1;
	rec_t pay_s1;
	op_t  op_s1;
	logic valid_s1;
	logic is_read, is_pend, is_gap;

	// one-port ring store, read data registered
	always_ff @(posedge clk) begin
		if (valid) begin
			if (job.op == OP_WRITE)
				mem_q[job.idx] <= job.rec;
			rd_s1 <= mem_q[job.idx];
			pay_s1 <= job.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1 <= OP_NONE;
		end else begin
			valid_s1 <= valid;
			op_s1 <= valid ? job.op : OP_NONE;
		end
	end

	assign is_read = (op_s1 == OP_READ);
	assign is_pend = (op_s1 == OP_PEND);
	assign is_gap  = (op_s1 == OP_GAP);

	assign strobe           = valid_s1;
	assign done_res         = is_read || is_gap || (op_s1 == OP_WRITE);
	assign rec_stamp        = is_read ? rd_s1.stamp : '0;
	assign rec_kind         = is_read ? rd_s1.kind : '0;
	assign rec_a            = is_read ? rd_s1.wa : '0;
	assign rec_b            = is_read ? rd_s1.wb : '0;
	assign pending_count    = is_pend ? pay_s1.stamp[PEND_W-1:0] : '0;
	assign dropped_count    = is_gap ? pay_s1.wa : '0;
	assign first_drop_stamp = is_gap ? pay_s1.wb : '0;
	assign drop_span        = is_gap ? pay_s1.stamp : '0;

endmodule
`default_nettype wire

FILE: src/trace_record_fifo_with_drop_gap.sv
`timescale 1ns / 1ps
`default_nettype none
// A command taken at a clock edge is pushed into the command queue; the back end then registers it,
// and its result word is on the outputs with strobe high.
// Throughput: one command per cycle; the back end drains one word per cycle and
// the receiver cannot stall it, so the two-entry command queue never fills and busy stays low.
// Reset: counters, drop account, queue and strobe cleared at once; ring store is not
// cleared, slots are only read after being written.
module trace_record_fifo_with_drop_gap (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [2:0]                    command,
	input  wire logic [7:0]                    kind,
	input  wire logic [31:0]                   word_a,
	input  wire logic [31:0]                   word_b,
	input  wire logic [31:0]                   cycle_stamp,
	input  wire logic [31:0]                   start_index,
	output logic                               strobe,
	output logic                               done_res,
	output logic [31:0]                        rec_stamp,
	output logic [7:0]                         rec_kind,
	output logic [31:0]                        rec_a,
	output logic [31:0]                        rec_b,
	output logic [trfdg_pkg::PEND_W-1:0]       pending_count,
	output logic [31:0]                        dropped_count,
	output logic [31:0]                        first_drop_stamp,
	output logic [31:0]                        drop_span
);
	import trfdg_pkg::*;

	job_t front_job, queue_job;
	logic accept, q_full, q_empty;

	assign busy   = q_full;
	assign accept = start && !q_full;

	trfdg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.kind        (kind),
		.word_a      (word_a),
		.word_b      (word_b),
		.cycle_stamp (cycle_stamp),
		.start_index (start_index),
		.job         (front_job)
	);

	trfdg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_job),
		.pop    (!q_empty),
		.full   (q_full),
		.empty  (q_empty),
		.dout   (queue_job)
	);

	trfdg_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid            (!q_empty),
		.job              (queue_job),
		.strobe           (strobe),
		.done_res         (done_res),
		.rec_stamp        (rec_stamp),
		.rec_kind         (rec_kind),
		.rec_a            (rec_a),
		.rec_b            (rec_b),
		.pending_count    (pending_count),
		.dropped_count    (dropped_count),
		.first_drop_stamp (first_drop_stamp),
		.drop_span        (drop_span)
	);

endmodule
`default_nettype wire

FILE: src/trfdg_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module trfdg_chk (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic                          strobe,
	input  wire logic                          done_res,
	input  wire logic [trfdg_pkg::PEND_W-1:0]  pending_count
);
	import trfdg_pkg::*;

	`TRF_ASSERT(a_word_two_after, clk, arst_n, (start && !busy) |-> ##2 strobe, "command gave no result word")
	`TRF_ASSERT(a_no_stray_word, clk, arst_n, strobe |-> $past(start && !busy, 2), "result word without command")
	`TRF_NEVER(a_done_needs_strobe, clk, arst_n, done_res && !strobe, "done_res outside result word")
	`TRF_NEVER(a_pend_clamped, clk, arst_n, pending_count > PEND_W'(SLOTS), "pending count above slot count")

endmodule

bind trace_record_fifo_with_drop_gap trfdg_chk u_trfdg_chk (.*);
`default_nettype wire
